// ----- rtl/gcr_pkg.sv -----
`default_nettype none

package gcr_pkg;

    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 8;
    localparam int FONT_BYTES = 180;
    localparam int DIGIT_BASE = 0;
    localparam int CAPS_BASE  = 50;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd4;

    localparam logic [15:0] FG_COLOR_RST      = 16'hFFFF;
    localparam logic [15:0] BG_COLOR_RST      = 16'h0000;
    localparam logic [3:0]  SCALE_RST         = 4'd1;
    localparam logic [9:0]  SCREEN_WIDTH_RST  = 10'd480;
    localparam logic [9:0]  SCREEN_HEIGHT_RST = 10'd320;

    // Character codes.
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PERIOD  = 8'h2E;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_APOS    = 8'h27;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CASE_FOLD  = 8'd32;

    // Column patterns of the symbol glyphs.
    localparam logic [7:0] SYM_BAR   = 8'h08;
    localparam logic [7:0] SYM_DOT   = 8'h40;
    localparam logic [7:0] SYM_COLON = 8'h22;
    localparam logic [7:0] SYM_ARC   = 8'h1C;

    typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_t;

    typedef struct packed {
        logic [15:0] fg_color;
        logic [15:0] bg_color;
        logic [3:0]  scale;
        logic [9:0]  screen_width;
        logic [9:0]  screen_height;
    } cfg_t;

    typedef struct packed {
        logic [9:0]  x;
        logic [9:0]  y;
        logic [3:0]  side;
        logic [15:0] color;
        logic        visible;
        logic        last;
    } cell_t;

    typedef struct packed {
        logic busy;
        logic last_cell;
    } seq_status_t;

    // Digits 0..9 followed by capitals A..Z, five column bytes each.
    localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
        8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
        8'h42,8'h61,8'h51,8'h49,8'h46, 8'h21,8'h41,8'h45,8'h4B,8'h31,
        8'h18,8'h14,8'h12,8'h7F,8'h10, 8'h27,8'h45,8'h45,8'h45,8'h39,
        8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
        8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E,
        8'h7F,8'h09,8'h09,8'h09,8'h7F, 8'h7F,8'h49,8'h49,8'h49,8'h36,
        8'h3E,8'h41,8'h41,8'h41,8'h22, 8'h7F,8'h41,8'h41,8'h22,8'h1C,
        8'h7F,8'h49,8'h49,8'h49,8'h41, 8'h7F,8'h09,8'h09,8'h09,8'h01,
        8'h3E,8'h41,8'h49,8'h49,8'h7A, 8'h7F,8'h08,8'h08,8'h08,8'h7F,
        8'h00,8'h41,8'h7F,8'h41,8'h00, 8'h20,8'h40,8'h41,8'h3F,8'h01,
        8'h7F,8'h08,8'h14,8'h22,8'h41, 8'h7F,8'h40,8'h40,8'h40,8'h40,
        8'h7F,8'h02,8'h0C,8'h02,8'h7F, 8'h7F,8'h04,8'h08,8'h10,8'h7F,
        8'h3E,8'h41,8'h41,8'h41,8'h3E, 8'h7F,8'h09,8'h09,8'h09,8'h06,
        8'h3E,8'h41,8'h51,8'h21,8'h5E, 8'h7F,8'h09,8'h19,8'h29,8'h46,
        8'h46,8'h49,8'h49,8'h49,8'h31, 8'h01,8'h01,8'h7F,8'h01,8'h01,
        8'h3F,8'h40,8'h40,8'h40,8'h3F, 8'h1F,8'h20,8'h40,8'h20,8'h1F,
        8'h3F,8'h40,8'h38,8'h40,8'h3F, 8'h63,8'h14,8'h08,8'h14,8'h63,
        8'h07,8'h08,8'h70,8'h08,8'h07, 8'h61,8'h51,8'h49,8'h45,8'h43
    };

endpackage

`default_nettype wire

// ----- rtl/glyph_cell_rasterizer_top.sv -----
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   char_code, origin_x, origin_y
// m_        out        m_valid / m_ready   cell_x, cell_y, cell_side, cell_color,
//                                          visible, last
// cfg_      in         cfg_we              cfg_index, cfg_wdata
//
// Each character covers 40 cells: the column/row counter emits one cell per cycle
// into the output register, and the next character is taken in the cycle the
// fortieth cell enters that register, so characters follow back to back.
// Reset (aresetn low at a clock edge) empties the pipeline and loads the
// register defaults. A low m_ready holds the output register and the counter.
`default_nettype none

module glyph_cell_rasterizer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_code,
    input  wire logic [8:0]  s_origin_x,
    input  wire logic [8:0]  s_origin_y,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [9:0]       m_cell_x,
    output logic [9:0]       m_cell_y,
    output logic [3:0]       m_cell_side,
    output logic [15:0]      m_cell_color,
    output logic             m_visible,
    output logic             m_last
);

    gcr_pkg::cfg_t        cfg_reg;
    gcr_pkg::glyph_t      glyph;
    gcr_pkg::cell_t       seq_cell;
    gcr_pkg::seq_status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fg_color      <= gcr_pkg::FG_COLOR_RST;
            cfg_reg.bg_color      <= gcr_pkg::BG_COLOR_RST;
            cfg_reg.scale         <= gcr_pkg::SCALE_RST;
            cfg_reg.screen_width  <= gcr_pkg::SCREEN_WIDTH_RST;
            cfg_reg.screen_height <= gcr_pkg::SCREEN_HEIGHT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                gcr_pkg::CFG_FG_COLOR:      cfg_reg.fg_color      <= cfg_wdata;
                gcr_pkg::CFG_BG_COLOR:      cfg_reg.bg_color      <= cfg_wdata;
                gcr_pkg::CFG_SCALE:         cfg_reg.scale         <= cfg_wdata[3:0];
                gcr_pkg::CFG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_wdata[9:0];
                gcr_pkg::CFG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    gcr_font_rom u_font_rom (
        .char_code (s_char_code),
        .glyph     (glyph)
    );

    gcr_cell_seq u_cell_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_glyph    (glyph),
        .in_origin_x (s_origin_x),
        .in_origin_y (s_origin_y),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_cell    (seq_cell),
        .status      (status)
    );

    assign m_cell_x     = seq_cell.x;
    assign m_cell_y     = seq_cell.y;
    assign m_cell_side  = seq_cell.side;
    assign m_cell_color = seq_cell.color;
    assign m_visible    = seq_cell.visible;
    assign m_last       = seq_cell.last;

`ifndef SYNTHESIS
    // A taken transaction always starts a character.
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> status.busy)
        else $error("sequencer not busy after input transaction");

    // With no character in flight the input side must be open.
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !status.busy |-> s_ready)
        else $error("input stalled while sequencer idle");

    // A visible cell has a nonzero side and ends inside the screen width.
    a_visible_fit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_visible) |->
            (m_cell_side != 4'd0
             && (11'(m_cell_x) + 11'(m_cell_side)) <= 11'(cfg_reg.screen_width)))
        else $error("visible cell exceeds screen width");
`endif

endmodule

`default_nettype wire

// ----- rtl/gcr_font_rom.sv -----
`default_nettype none

module gcr_font_rom (
    input  wire logic [7:0]      char_code,
    output gcr_pkg::glyph_t      glyph
);

    logic [7:0] code;
    logic [7:0] base;
    logic       from_rom;

    always_comb begin
        code = char_code;
        if (code >= gcr_pkg::CH_LOWER_A && code <= gcr_pkg::CH_LOWER_Z) begin
            code = code - gcr_pkg::CASE_FOLD;
        end

        base     = '0;
        from_rom = 1'b0;
        glyph    = '0;

        if (code >= gcr_pkg::CH_ZERO && code <= gcr_pkg::CH_NINE) begin
            from_rom = 1'b1;
            base = 8'(gcr_pkg::DIGIT_BASE) + 8'((code - gcr_pkg::CH_ZERO) * 8'(gcr_pkg::GLYPH_COLS));
        end else if (code >= gcr_pkg::CH_UPPER_A && code <= gcr_pkg::CH_UPPER_Z) begin
            from_rom = 1'b1;
            base = 8'(gcr_pkg::CAPS_BASE)
                 + 8'((code - gcr_pkg::CH_UPPER_A) * 8'(gcr_pkg::GLYPH_COLS));
        end

        if (from_rom) begin
            for (int k = 0; k < gcr_pkg::GLYPH_COLS; k++) begin
                glyph[k] = gcr_pkg::FONT_ROM[base + 8'(k)];
            end
        end else begin
            unique case (code)
                gcr_pkg::CH_MINUS: begin
                    for (int k = 0; k < gcr_pkg::GLYPH_COLS; k++) begin
                        glyph[k] = gcr_pkg::SYM_BAR;
                    end
                end
                gcr_pkg::CH_PERIOD: glyph[2] = gcr_pkg::SYM_DOT;
                gcr_pkg::CH_COLON:  glyph[2] = gcr_pkg::SYM_COLON;
                gcr_pkg::CH_LPAREN: begin
                    glyph[1] = gcr_pkg::SYM_ARC;
                    glyph[2] = gcr_pkg::SYM_COLON;
                end
                gcr_pkg::CH_RPAREN: begin
                    glyph[0] = gcr_pkg::SYM_COLON;
                    glyph[1] = gcr_pkg::SYM_ARC;
                end
                gcr_pkg::CH_APOS:   glyph[1] = 8'h02;
                gcr_pkg::CH_QUOTE: begin
                    glyph[0] = 8'h06;
                    glyph[2] = 8'h06;
                end
                gcr_pkg::CH_QUEST: begin
                    glyph[0] = 8'h20;
                    glyph[1] = 8'h40;
                    glyph[2] = 8'h45;
                    glyph[3] = 8'h48;
                    glyph[4] = 8'h30;
                end
                default: glyph = '0;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/gcr_cell_seq.sv -----
`default_nettype none

module gcr_cell_seq (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire gcr_pkg::cfg_t        cfg,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire gcr_pkg::glyph_t      in_glyph,
    input  wire logic [8:0]           in_origin_x,
    input  wire logic [8:0]           in_origin_y,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output gcr_pkg::cell_t            out_cell,
    output gcr_pkg::seq_status_t      status
);

    localparam logic [2:0] COL_LAST = 3'(gcr_pkg::GLYPH_COLS - 1);
    localparam logic [2:0] ROW_LAST = 3'(gcr_pkg::GLYPH_ROWS - 1);

    gcr_pkg::glyph_t glyph_reg;
    logic [8:0]      ox_reg;
    logic [8:0]      oy_reg;
    logic [2:0]      col_reg;
    logic [2:0]      row_reg;
    logic            busy_reg;
    logic            out_valid_reg;
    gcr_pkg::cell_t  cell_reg;
    gcr_pkg::cell_t  cell_next;

    logic       last_cell;
    logic       advance;
    logic       accept;
    logic [6:0] off_x;
    logic [6:0] off_y;
    logic [10:0] end_x;
    logic [10:0] end_y;
    logic       bit_on;

    assign last_cell = (col_reg == COL_LAST) && (row_reg == ROW_LAST);
    // While busy, the counter moves whenever the output register is free or being emptied.
    assign advance   = busy_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !busy_reg || (advance && last_cell);
    assign accept    = in_valid && in_ready;

    assign off_x  = 7'(col_reg) * 7'(cfg.scale);
    assign off_y  = 7'(row_reg) * 7'(cfg.scale);
    assign bit_on = glyph_reg[col_reg][row_reg];

    always_comb begin
        cell_next.x       = 10'(ox_reg) + 10'(off_x);
        cell_next.y       = 10'(oy_reg) + 10'(off_y);
        cell_next.side    = cfg.scale;
        cell_next.color   = bit_on ? cfg.fg_color : cfg.bg_color;
        end_x             = 11'(cell_next.x) + 11'(cfg.scale);
        end_y             = 11'(cell_next.y) + 11'(cfg.scale);
        cell_next.visible = (cfg.scale != 4'd0)
                          && (end_x <= 11'(cfg.screen_width))
                          && (end_y <= 11'(cfg.screen_height));
        cell_next.last    = last_cell;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                busy_reg <= 1'b1;
                col_reg  <= '0;
                row_reg  <= '0;
            end else if (advance) begin
                if (last_cell) begin
                    busy_reg <= 1'b0;
                end else if (row_reg == ROW_LAST) begin
                    row_reg <= '0;
                    col_reg <= col_reg + 3'd1;
                end else begin
                    row_reg <= row_reg + 3'd1;
                end
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            glyph_reg <= in_glyph;
            ox_reg    <= in_origin_x;
            oy_reg    <= in_origin_y;
        end
        if (advance) begin
            cell_reg <= cell_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_cell         = cell_reg;
    assign status.busy      = busy_reg;
    assign status.last_cell = last_cell;

endmodule

`default_nettype wire
